>>> rtl/fnhe_pkg.sv
`timescale 1ns / 1ps
// fnhe_pkg: shared types and constants for the position string to hex code encoder
// no dependencies; used by fnhe_front, fnhe_queue, fnhe_back and the top level

package fnhe_pkg;

	// default depth of the queue between front and back
	localparam int QUEUE_DEPTH_DEF = 2;

	// at most this many code characters come out of one input character
	localparam int MAX_RESULTS = 4;
	localparam int RES_IDX_W   = $clog2(MAX_RESULTS);
	localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

	localparam logic [7:0] CH_ZERO = 8'h30;  // ascii '0'
	localparam logic [7:0] CH_NUL  = 8'h00;  // end marker character

	// number of code characters one input character pushes
	localparam logic [1:0] PUSH_NONE = 2'd0;
	localparam logic [1:0] PUSH_ONE  = 2'd1;
	localparam logic [1:0] PUSH_TWO  = 2'd2;

	// one classified input character, as passed from front to back
	typedef struct packed {
		logic [7:0] c1;    // first pushed code character
		logic [7:0] c2;    // second pushed code character
		logic [1:0] n;     // how many of c1, c2 are pushed
		logic       last;  // final character of the string
	} entry_t;

endpackage

>>> rtl/fnhe_front.sv
`timescale 1ns / 1ps
// fnhe_front: section tracking and character mapping of the input stream
// depends on fnhe_pkg

module fnhe_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [7:0]       in_char,
	input  logic             in_last,
	input  logic             q_full,
	output logic             full,
	output logic             q_wr,
	output fnhe_pkg::entry_t q_wdata
);

	typedef enum logic [3:0] {
		PH_BOARD = 4'b0001,
		PH_SIDE  = 4'b0010,
		PH_SKIP  = 4'b0100,
		PH_TAIL  = 4'b1000
	} phase_t;

	phase_t phase_q;
	phase_t phase_d;
	logic   accept;

	function automatic logic [7:0] board_map(input logic [7:0] c);
		logic [7:0] m;
		case (c)
			"1": m = "0";
			"2": m = "1";
			"3": m = "2";
			"p": m = "3";
			"n": m = "4";
			"b": m = "5";
			"r": m = "6";
			"q": m = "7";
			"k": m = "9";
			"P": m = "a";
			"N": m = "b";
			"B": m = "c";
			"R": m = "d";
			"Q": m = "e";
			"K": m = "f";
			default: m = "8";
		endcase
		return m;
	endfunction

	function automatic logic [7:0] tail_map(input logic [7:0] c);
		logic [7:0] m;
		if (c >= "a" && c <= "h") begin
			m = c - 8'h30;  // a..h to 1..8
		end else if (c >= "B" && c <= "G") begin
			m = "e";
		end else begin
			case (c)
				"-": m = "0";
				"K": m = "a";
				"Q": m = "b";
				"k": m = "c";
				"q": m = "d";
				" ": m = "9";
				default: m = c;
			endcase
		end
		return m;
	endfunction

	assign full   = q_full;
	assign accept = push && !q_full;

	always_comb begin
		logic [7:0] m;
		m = tail_map(in_char);
		phase_d      = phase_q;
		q_wdata.c1   = fnhe_pkg::CH_ZERO;
		q_wdata.c2   = fnhe_pkg::CH_ZERO;
		q_wdata.n    = fnhe_pkg::PUSH_NONE;
		q_wdata.last = in_last;
		case (phase_q)
			PH_BOARD: begin
				if (in_char == " ") begin
					phase_d = PH_SIDE;
					// a lone trailing space still gives the side digit
					if (in_last) begin
						q_wdata.n = fnhe_pkg::PUSH_ONE;
					end
				end else if (in_char != "/") begin
					q_wdata.c1 = board_map(in_char);
					q_wdata.n  = fnhe_pkg::PUSH_ONE;
					if (in_char >= "4" && in_char <= "8") begin
						q_wdata.c2 = in_char - 8'd4;
						q_wdata.n  = fnhe_pkg::PUSH_TWO;
					end
				end
			end
			PH_SIDE: begin
				q_wdata.c1 = (in_char == "b") ? "1" : "0";
				q_wdata.n  = fnhe_pkg::PUSH_ONE;
				phase_d    = PH_SKIP;
			end
			PH_SKIP: begin
				phase_d = PH_TAIL;
			end
			PH_TAIL: begin
				q_wdata.c1 = m;
				q_wdata.n  = fnhe_pkg::PUSH_ONE;
				if (m == "e") begin
					q_wdata.c2 = in_char - 8'h10;  // 'B'..'G' to '2'..'7'
					q_wdata.n  = fnhe_pkg::PUSH_TWO;
				end
			end
			default: begin
				phase_d = PH_BOARD;
			end
		endcase
		if (in_last) begin
			phase_d = PH_BOARD;
		end
	end

	// characters that push nothing and end nothing need no queue slot
	assign q_wr = accept && ((q_wdata.n != fnhe_pkg::PUSH_NONE) || in_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_BOARD;
		end else if (accept) begin
			phase_q <= phase_d;
		end
	end

endmodule

>>> rtl/fnhe_queue.sv
`timescale 1ns / 1ps
// fnhe_queue: small register queue of classified characters between front and back
// depends on fnhe_pkg

module fnhe_queue #(
	parameter int DEPTH = fnhe_pkg::QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  fnhe_pkg::entry_t wdata,
	input  logic             rd,
	output fnhe_pkg::entry_t rdata,
	output logic             full,
	output logic             empty
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	fnhe_pkg::entry_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign full  = (cnt_q == CNT_W'(DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rd_ptr_q];
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

>>> rtl/fnhe_back.sv
`timescale 1ns / 1ps
// fnhe_back: hold-back of the newest code character, odd-length fix-up and result drain
// depends on fnhe_pkg

module fnhe_back (
	input  logic             clk,
	input  logic             arst_n,
	input  fnhe_pkg::entry_t q_rdata,
	input  logic             q_empty,
	output logic             q_rd,
	input  logic             pop,
	output logic             empty,
	output logic [7:0]       out_char,
	output logic             out_last
);

	localparam int IW = fnhe_pkg::RES_IDX_W;
	localparam int CW = fnhe_pkg::RES_CNT_W;
	localparam int NR = fnhe_pkg::MAX_RESULTS;

	logic          held_valid_q;
	logic [7:0]    held_char_q;
	logic          odd_q;
	logic [7:0]    res_char_q [NR];
	logic          res_last_q [NR];
	logic [CW-1:0] res_cnt_q;
	logic [CW-1:0] res_idx_q;

	logic          h_d;
	logic [7:0]    hc_d;
	logic          o_d;
	logic [7:0]    lc [NR];
	logic          ll [NR];
	logic [CW-1:0] lcnt;
	logic          drain_end;

	// expand one queue entry into its list of results and the next hold state
	always_comb begin
		logic [CW-1:0] lprev;
		h_d  = held_valid_q;
		hc_d = held_char_q;
		o_d  = odd_q;
		lcnt = '0;
		for (int i = 0; i < NR; i++) begin
			lc[i] = fnhe_pkg::CH_NUL;
			ll[i] = 1'b0;
		end
		if (q_rdata.n != fnhe_pkg::PUSH_NONE) begin
			if (h_d) begin
				lc[lcnt[IW-1:0]] = hc_d;
				lcnt = lcnt + 1'b1;
			end
			hc_d = q_rdata.c1;
			h_d  = 1'b1;
			o_d  = ~o_d;
		end
		if (q_rdata.n == fnhe_pkg::PUSH_TWO) begin
			lc[lcnt[IW-1:0]] = hc_d;
			lcnt = lcnt + 1'b1;
			hc_d = q_rdata.c2;
			o_d  = ~o_d;
		end
		lprev = lcnt - 1'b1;
		if (q_rdata.last) begin
			if (o_d && h_d && hc_d == fnhe_pkg::CH_ZERO) begin
				// drop the trailing zero; the character before it becomes final
				if (lcnt != '0) begin
					ll[lprev[IW-1:0]] = 1'b1;
				end else begin
					lc[lcnt[IW-1:0]] = fnhe_pkg::CH_NUL;
					ll[lcnt[IW-1:0]] = 1'b1;
					lcnt = lcnt + 1'b1;
				end
			end else if (o_d && h_d) begin
				lc[lcnt[IW-1:0]] = hc_d;
				lcnt = lcnt + 1'b1;
				lc[lcnt[IW-1:0]] = fnhe_pkg::CH_ZERO;
				ll[lcnt[IW-1:0]] = 1'b1;
				lcnt = lcnt + 1'b1;
			end else if (h_d) begin
				lc[lcnt[IW-1:0]] = hc_d;
				ll[lcnt[IW-1:0]] = 1'b1;
				lcnt = lcnt + 1'b1;
			end else begin
				lc[lcnt[IW-1:0]] = fnhe_pkg::CH_NUL;
				ll[lcnt[IW-1:0]] = 1'b1;
				lcnt = lcnt + 1'b1;
			end
			h_d  = 1'b0;
			hc_d = fnhe_pkg::CH_NUL;
			o_d  = 1'b0;
		end
	end

	assign empty     = (res_idx_q == res_cnt_q);
	assign out_char  = res_char_q[res_idx_q[IW-1:0]];
	assign out_last  = res_last_q[res_idx_q[IW-1:0]];
	assign drain_end = pop && !empty && ((res_idx_q + 1'b1) == res_cnt_q);
	assign q_rd      = !q_empty && (empty || drain_end);

	always_ff @(posedge clk) begin
		if (q_rd) begin
			for (int i = 0; i < NR; i++) begin
				res_char_q[i] <= lc[i];
				res_last_q[i] <= ll[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_valid_q <= 1'b0;
			held_char_q  <= '0;
			odd_q        <= 1'b0;
			res_cnt_q    <= '0;
			res_idx_q    <= '0;
		end else if (q_rd) begin
			held_valid_q <= h_d;
			held_char_q  <= hc_d;
			odd_q        <= o_d;
			res_cnt_q    <= lcnt;
			res_idx_q    <= '0;
		end else if (pop && !empty) begin
			res_idx_q <= res_idx_q + 1'b1;
		end
	end

endmodule

>>> rtl/fen_to_hex_nibble_encoder.sv
`timescale 1ns / 1ps
// fen_to_hex_nibble_encoder: top level of the position string to hex code encoder
// depends on fnhe_pkg, fnhe_front, fnhe_queue, fnhe_back
//
// channel   direction  handshake          payload
// input     in         push / full        in_char[7:0], in_last
// result    out        pop / empty        out_char[7:0], out_last
//
// an input transaction is taken on any cycle the queue has room; the front maps it
// in the same cycle and writes at most one queue entry
// the back takes an entry when its result list drains and expands it into 0 to 4
// results, one result transaction per cycle while pop is held; the result port is
// the bottleneck, and the next entry is taken in the same cycle as the last result
// of the current one is popped
// reset clears the section state, the queue, the held character and the result list
// a stall on the result side fills the queue, then raises full; nothing is lost

module fen_to_hex_nibble_encoder #(
	parameter int QUEUE_DEPTH = fnhe_pkg::QUEUE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] in_char,
	input  logic       in_last,
	input  logic       pop,
	output logic       empty,
	output logic [7:0] out_char,
	output logic       out_last
);

	// front to queue
	logic             q_wr;
	logic             q_full;
	fnhe_pkg::entry_t q_wdata;
	// queue to back
	logic             q_rd;
	logic             q_empty;
	fnhe_pkg::entry_t q_rdata;

	// section tracking and per-character mapping
	fnhe_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.in_char (in_char),
		.in_last (in_last),
		.q_full  (q_full),
		.full    (full),
		.q_wr    (q_wr),
		.q_wdata (q_wdata)
	);

	// decouples input acceptance from result draining
	fnhe_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_wr),
		.wdata  (q_wdata),
		.rd     (q_rd),
		.rdata  (q_rdata),
		.full   (q_full),
		.empty  (q_empty)
	);

	// hold-back, parity fix-up and the result list
	fnhe_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_rdata  (q_rdata),
		.q_empty  (q_empty),
		.q_rd     (q_rd),
		.pop      (pop),
		.empty    (empty),
		.out_char (out_char),
		.out_last (out_last)
	);

`ifndef SYNTHESIS
	// the front never writes into a full queue
	assert property (@(posedge clk) disable iff (!arst_n) q_wr |-> !q_full)
		else $error("queue written while full");

	// an entry that pushes nothing only exists to close a string
	assert property (@(posedge clk) disable iff (!arst_n)
		(q_wr && q_wdata.n == fnhe_pkg::PUSH_NONE) |-> q_wdata.last)
		else $error("empty queue entry without end of string");

	// one character pushes at most two code characters
	assert property (@(posedge clk) disable iff (!arst_n)
		q_wr |-> (q_wdata.n == fnhe_pkg::PUSH_NONE || q_wdata.n == fnhe_pkg::PUSH_ONE ||
			q_wdata.n == fnhe_pkg::PUSH_TWO))
		else $error("bad push count in queue entry");
`endif

endmodule
